[rtl/vrp_pkg.sv]
// ============================================================================
// vrp_pkg: shared types, constants and arithmetic helpers
// Register map, reset values, the quarter-wave sine table and the 16:16
// fixed-point multiply used by the matrix sequencer and the vertex path.
// ============================================================================
`default_nettype none

package vrp_pkg;

    // APB register map (word index)
    localparam int          APB_ADDR_W        = 5;
    localparam logic [2:0]  REG_DEPTH_OFFSET  = 3'd0;
    localparam logic [2:0]  REG_CENTER_X      = 3'd1;
    localparam logic [2:0]  REG_CENTER_Y      = 3'd2;
    localparam logic [2:0]  REG_STEP_X        = 3'd3;
    localparam logic [2:0]  REG_STEP_Y        = 3'd4;
    localparam logic [2:0]  REG_STEP_Z        = 3'd5;

    // Register reset values
    localparam logic [14:0] DEPTH_OFFSET_RST  = 15'd10;
    localparam logic [9:0]  CENTER_X_RST      = 10'd160;
    localparam logic [9:0]  CENTER_Y_RST      = 10'd88;
    localparam logic [7:0]  STEP_X_RST        = 8'd1;
    localparam logic [7:0]  STEP_Y_RST        = 8'd2;
    localparam logic [7:0]  STEP_Z_RST        = 8'd1;

    // Fixed point one, and the divider depth (one quotient bit per stage)
    localparam logic [31:0] FIX_ONE           = 32'h0001_0000;
    localparam int          DIV_STEPS         = 32;
    localparam int          DIV_W             = 26;

    // Matrix rebuild sequence length
    localparam logic [3:0]  SEQ_LAST          = 4'd15;

    // Command codes
    localparam logic        CMD_VERTEX        = 1'b0;
    localparam logic        CMD_FRAME         = 1'b1;

    // First quadrant of round(256 * sin(2*pi*i/256)), i = 0..64.
    localparam logic [8:0] QUARTER_SINE [0:64] = '{
        9'd0,   9'd6,   9'd13,  9'd19,  9'd25,  9'd31,  9'd38,  9'd44,
        9'd50,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
        9'd98,  9'd104, 9'd109, 9'd115, 9'd121, 9'd126, 9'd132, 9'd137,
        9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd172, 9'd177,
        9'd181, 9'd185, 9'd190, 9'd194, 9'd198, 9'd202, 9'd206, 9'd209,
        9'd213, 9'd216, 9'd220, 9'd223, 9'd226, 9'd229, 9'd231, 9'd234,
        9'd237, 9'd239, 9'd241, 9'd243, 9'd245, 9'd247, 9'd248, 9'd250,
        9'd251, 9'd252, 9'd253, 9'd254, 9'd255, 9'd255, 9'd256, 9'd256,
        9'd256
    };

    // One divider stage: remainders and shifting dividend/quotient words.
    typedef struct packed {
        logic               fault;
        logic               neg_x;
        logic               neg_y;
        logic [DIV_W-1:0]   rem_x;
        logic [31:0]        quo_x;
        logic [DIV_W-1:0]   rem_y;
        logic [31:0]        quo_y;
        logic [DIV_W-1:0]   divisor;
    } div_stage_t;

    // Sine of an 8-bit angle, amplitude 256, from quarter-wave symmetry.
    function automatic logic signed [9:0] sine_value(input logic [7:0] a);
        logic [6:0] q;
        logic [6:0] q_mirror;
        logic [9:0] v;
        q        = {1'b0, a[5:0]};
        q_mirror = 7'd64 - q;
        case (a[7:6])
            2'd0:    v = {1'b0, QUARTER_SINE[q]};
            2'd1:    v = {1'b0, QUARTER_SINE[q_mirror]};
            2'd2:    v = 10'd0 - {1'b0, QUARTER_SINE[q]};
            default: v = 10'd0 - {1'b0, QUARTER_SINE[q_mirror]};
        endcase
        return signed'(v);
    endfunction

    // Sine value scaled into 16:16 (ROM value times 256).
    function automatic logic [31:0] trig_value(input logic [7:0] a);
        logic [9:0] s;
        s = sine_value(a);
        return {{14{s[9]}}, s, 8'd0};
    endfunction

    // Shift-multiply: both operands drop six fraction bits, the product
    // wraps to 32 bits and drops four more.
    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic signed [25:0] as;
        logic signed [25:0] bs;
        logic signed [51:0] p;
        as = signed'(a[31:6]);
        bs = signed'(b[31:6]);
        p  = as * bs;
        return {{4{p[31]}}, p[31:4]};
    endfunction

endpackage

`default_nettype wire

[rtl/vrp_vertex_if.sv]
// ============================================================================
// vrp_vertex_if: vertex request channel
// Valid/ready channel carrying a command and one 16:16 vertex.
// ============================================================================
`default_nettype none

interface vrp_vertex_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;

    modport source (output valid, command, vertex_x, vertex_y, vertex_z, input ready);
    modport sink   (input valid, command, vertex_x, vertex_y, vertex_z, output ready);
endinterface

`default_nettype wire

[rtl/vrp_screen_if.sv]
// ============================================================================
// vrp_screen_if: projected point channel
// Valid/ready channel carrying screen coordinates and the divide fault flag.
// ============================================================================
`default_nettype none

interface vrp_screen_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               divide_fault;

    modport source (output valid, screen_x, screen_y, divide_fault, input ready);
    modport sink   (input valid, screen_x, screen_y, divide_fault, output ready);
endinterface

`default_nettype wire

[rtl/vertex_rotate_perspective_project_core.sv]
// ============================================================================
// vertex_rotate_perspective_project_core: rotate and project vertices
// Rotates 16:16 vertices by a frame matrix built from a sine ROM, offsets
// depth and projects them perspectively onto a centered screen.
// ============================================================================
//
//  Channel  Role      Contents
//  -------  --------  ------------------------------------------------------
//  vtx      sink      command, vertex_x, vertex_y, vertex_z
//  pix      source    screen_x, screen_y, divide_fault
//  APB      slave     depth_offset, center_x/y, step_x/y/z at 4*index
//
//  A vertex request is taken every cycle while the output is not stalled and
//  no rebuild is running; its result passes through multiply, sum, sign prep,
//  32 restoring divider stages and an output register. A frame request produces
//  no result and blocks the channel while a shared multiplier rebuilds the matrix one product per cycle.
//  A stall at the output freezes the whole pipeline; nothing is dropped.
//  Reset restores registers, clears angles and loads the identity matrix.
// ============================================================================
`default_nettype none

module vertex_rotate_perspective_project_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [vrp_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    vrp_vertex_if.sink                             vtx,
    vrp_screen_if.source                           pix
);

    localparam int NS = vrp_pkg::DIV_STEPS;
    localparam int DW = vrp_pkg::DIV_W;

    // Configuration registers
    logic [14:0] depth_offset_reg;
    logic [9:0]  center_x_reg;
    logic [9:0]  center_y_reg;
    logic [7:0]  step_x_reg;
    logic [7:0]  step_y_reg;
    logic [7:0]  step_z_reg;
    logic        cfg_write;

    // Frame state and rebuild sequencer
    logic [7:0]  angle_x_reg;
    logic [7:0]  angle_y_reg;
    logic [7:0]  angle_z_reg;
    logic [31:0] matrix_reg [0:8];
    logic [31:0] scratch_reg [0:14];
    logic        busy_reg;
    logic [3:0]  seq_step_reg;
    logic [31:0] sx, sy, sz, cx, cy, cz;
    logic [31:0] op_a, op_b, seq_prod;

    // Pipeline
    logic        advance;
    logic        accept;
    logic        vertex_accept;
    logic        frame_accept;
    logic        s1_valid_reg;
    logic [31:0] s1_prod_reg [0:8];
    logic        s2_valid_reg;
    logic [31:0] rx_reg, ry_reg, rz_reg;
    logic        div_valid_reg [0:NS];
    vrp_pkg::div_stage_t div_reg [0:NS];
    vrp_pkg::div_stage_t div_prep;
    logic [31:0] num_x, num_y;
    logic [DW-1:0] den;
    logic [31:0] sq_x, sq_y, res_x, res_y;
    logic        pix_valid_reg;
    logic [31:0] pix_x_reg, pix_y_reg;
    logic        pix_fault_reg;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_offset_reg <= vrp_pkg::DEPTH_OFFSET_RST;
            center_x_reg     <= vrp_pkg::CENTER_X_RST;
            center_y_reg     <= vrp_pkg::CENTER_Y_RST;
            step_x_reg       <= vrp_pkg::STEP_X_RST;
            step_y_reg       <= vrp_pkg::STEP_Y_RST;
            step_z_reg       <= vrp_pkg::STEP_Z_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                vrp_pkg::REG_DEPTH_OFFSET: depth_offset_reg <= pwdata[14:0];
                vrp_pkg::REG_CENTER_X:     center_x_reg     <= pwdata[9:0];
                vrp_pkg::REG_CENTER_Y:     center_y_reg     <= pwdata[9:0];
                vrp_pkg::REG_STEP_X:       step_x_reg       <= pwdata[7:0];
                vrp_pkg::REG_STEP_Y:       step_y_reg       <= pwdata[7:0];
                vrp_pkg::REG_STEP_Z:       step_z_reg       <= pwdata[7:0];
                default:                   ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[4:2])
            vrp_pkg::REG_DEPTH_OFFSET: prdata = {17'd0, depth_offset_reg};
            vrp_pkg::REG_CENTER_X:     prdata = {22'd0, center_x_reg};
            vrp_pkg::REG_CENTER_Y:     prdata = {22'd0, center_y_reg};
            vrp_pkg::REG_STEP_X:       prdata = {24'd0, step_x_reg};
            vrp_pkg::REG_STEP_Y:       prdata = {24'd0, step_y_reg};
            vrp_pkg::REG_STEP_Z:       prdata = {24'd0, step_z_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: the whole pipeline moves when the output can take data.
    // ------------------------------------------------------------------
    assign advance       = !pix_valid_reg || pix.ready;
    assign vtx.ready     = advance && !busy_reg;
    assign accept        = vtx.valid && vtx.ready;
    assign vertex_accept = accept && (vtx.command == vrp_pkg::CMD_VERTEX);
    assign frame_accept  = accept && (vtx.command == vrp_pkg::CMD_FRAME);

    // ------------------------------------------------------------------
    // Matrix rebuild: one shared multiply per sequencer step.
    // ------------------------------------------------------------------
    assign sx = vrp_pkg::trig_value(angle_x_reg);
    assign sy = vrp_pkg::trig_value(angle_y_reg);
    assign sz = vrp_pkg::trig_value(angle_z_reg);
    assign cx = vrp_pkg::trig_value(angle_x_reg + 8'd64);
    assign cy = vrp_pkg::trig_value(angle_y_reg + 8'd64);
    assign cz = vrp_pkg::trig_value(angle_z_reg + 8'd64);

    // Operand selection for each product of the rebuild.
    always_comb
    begin
        case (seq_step_reg)
            4'd0:    begin op_a = cx;              op_b = cz; end
            4'd1:    begin op_a = sx;              op_b = sy; end
            4'd2:    begin op_a = scratch_reg[1];  op_b = sz; end
            4'd3:    begin op_a = cx;              op_b = sx; end
            4'd4:    begin op_a = scratch_reg[3];  op_b = sy; end
            4'd5:    begin op_a = cx;              op_b = sz; end
            4'd6:    begin op_a = cy;              op_b = sx; end
            4'd7:    begin op_a = cy;              op_b = sz; end
            4'd8:    begin op_a = cy;              op_b = cz; end
            4'd9:    begin op_a = cx;              op_b = sy; end
            4'd10:   begin op_a = scratch_reg[9];  op_b = sz; end
            4'd11:   begin op_a = cz;              op_b = sx; end
            4'd12:   begin op_a = sx;              op_b = sz; end
            4'd13:   begin op_a = scratch_reg[0];  op_b = sy; end
            4'd14:   begin op_a = cx;              op_b = cy; end
            default: begin op_a = 32'd0;           op_b = 32'd0; end
        endcase
    end

    assign seq_prod = vrp_pkg::fmul(op_a, op_b);

    // Scratch products, captured by step.
    always_ff @(posedge clk)
    begin
        if (busy_reg && (seq_step_reg != vrp_pkg::SEQ_LAST))
        begin
            scratch_reg[seq_step_reg] <= seq_prod;
        end
    end

    // Angles, sequencer control and the matrix itself.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg  <= 8'd0;
            angle_y_reg  <= 8'd0;
            angle_z_reg  <= 8'd0;
            busy_reg     <= 1'b0;
            seq_step_reg <= 4'd0;
            for (int i = 0; i < 9; i++)
            begin
                matrix_reg[i] <= ((i % 4) == 0) ? vrp_pkg::FIX_ONE : 32'd0;
            end
        end
        else if (frame_accept)
        begin
            angle_x_reg  <= angle_x_reg + step_x_reg;
            angle_y_reg  <= angle_y_reg + step_y_reg;
            angle_z_reg  <= angle_z_reg + step_z_reg;
            busy_reg     <= 1'b1;
            seq_step_reg <= 4'd0;
        end
        else if (busy_reg)
        begin
            seq_step_reg <= seq_step_reg + 4'd1;
            if (seq_step_reg == vrp_pkg::SEQ_LAST)
            begin
                busy_reg      <= 1'b0;
                matrix_reg[0] <= scratch_reg[0] + scratch_reg[2];
                matrix_reg[3] <= scratch_reg[4] - scratch_reg[5];
                matrix_reg[6] <= scratch_reg[6];
                matrix_reg[1] <= scratch_reg[7];
                matrix_reg[4] <= scratch_reg[8];
                matrix_reg[7] <= 32'd0 - sy;
                matrix_reg[2] <= scratch_reg[10] - scratch_reg[11];
                matrix_reg[5] <= scratch_reg[12] + scratch_reg[13];
                matrix_reg[8] <= scratch_reg[14];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: nine products of the vertex with the matrix.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_reg[0] <= vrp_pkg::fmul(vtx.vertex_x, matrix_reg[0]);
            s1_prod_reg[1] <= vrp_pkg::fmul(vtx.vertex_y, matrix_reg[3]);
            s1_prod_reg[2] <= vrp_pkg::fmul(vtx.vertex_z, matrix_reg[6]);
            s1_prod_reg[3] <= vrp_pkg::fmul(vtx.vertex_x, matrix_reg[1]);
            s1_prod_reg[4] <= vrp_pkg::fmul(vtx.vertex_y, matrix_reg[4]);
            s1_prod_reg[5] <= vrp_pkg::fmul(vtx.vertex_z, matrix_reg[7]);
            s1_prod_reg[6] <= vrp_pkg::fmul(vtx.vertex_x, matrix_reg[2]);
            s1_prod_reg[7] <= vrp_pkg::fmul(vtx.vertex_y, matrix_reg[5]);
            s1_prod_reg[8] <= vrp_pkg::fmul(vtx.vertex_z, matrix_reg[8]);
        end
    end

    // Stage 2: rotated coordinates, depth offset in whole units.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rx_reg <= s1_prod_reg[0] + s1_prod_reg[1] + s1_prod_reg[2];
            ry_reg <= s1_prod_reg[3] + s1_prod_reg[4] + s1_prod_reg[5];
            rz_reg <= s1_prod_reg[6] + s1_prod_reg[7] + s1_prod_reg[8]
                      + {1'b0, depth_offset_reg, 16'd0};
        end
    end

    // Stage 3: dividend and divisor magnitudes with quotient signs.
    assign num_x = {rx_reg[25:0], 6'd0};
    assign num_y = {ry_reg[25:0], 6'd0};
    assign den   = rz_reg[31:6];

    always_comb
    begin
        div_prep.fault   = (den == '0);
        div_prep.neg_x   = num_x[31] ^ den[DW-1];
        div_prep.neg_y   = num_y[31] ^ den[DW-1];
        div_prep.rem_x   = '0;
        div_prep.rem_y   = '0;
        div_prep.quo_x   = num_x[31] ? (32'd0 - num_x) : num_x;
        div_prep.quo_y   = num_y[31] ? (32'd0 - num_y) : num_y;
        div_prep.divisor = den[DW-1] ? ('0 - den) : den;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_reg[0] <= div_prep;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: one quotient bit per stage for both coordinates.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        logic [DW:0] trial_x;
        logic [DW:0] trial_y;
        logic        take_x;
        logic        take_y;

        assign trial_x = {div_reg[k].rem_x, div_reg[k].quo_x[31]};
        assign trial_y = {div_reg[k].rem_y, div_reg[k].quo_y[31]};
        assign take_x  = trial_x >= {1'b0, div_reg[k].divisor};
        assign take_y  = trial_y >= {1'b0, div_reg[k].divisor};

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                div_reg[k+1].fault   <= div_reg[k].fault;
                div_reg[k+1].neg_x   <= div_reg[k].neg_x;
                div_reg[k+1].neg_y   <= div_reg[k].neg_y;
                div_reg[k+1].divisor <= div_reg[k].divisor;
                div_reg[k+1].rem_x   <= take_x
                    ? DW'(trial_x - {1'b0, div_reg[k].divisor}) : trial_x[DW-1:0];
                div_reg[k+1].rem_y   <= take_y
                    ? DW'(trial_y - {1'b0, div_reg[k].divisor}) : trial_y[DW-1:0];
                div_reg[k+1].quo_x   <= {div_reg[k].quo_x[30:0], take_x};
                div_reg[k+1].quo_y   <= {div_reg[k].quo_y[30:0], take_y};
            end
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i <= NS; i++)
            begin
                div_valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            s1_valid_reg     <= vertex_accept;
            s2_valid_reg     <= s1_valid_reg;
            div_valid_reg[0] <= s2_valid_reg;
            for (int i = 0; i < NS; i++)
            begin
                div_valid_reg[i+1] <= div_valid_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: apply sign, drop four fraction bits, add screen center; a fault zeroes both.
    // ------------------------------------------------------------------
    assign sq_x  = div_reg[NS].neg_x ? (32'd0 - div_reg[NS].quo_x) : div_reg[NS].quo_x;
    assign sq_y  = div_reg[NS].neg_y ? (32'd0 - div_reg[NS].quo_y) : div_reg[NS].quo_y;
    assign res_x = {{4{sq_x[31]}}, sq_x[31:4]} + {22'd0, center_x_reg};
    assign res_y = {{4{sq_y[31]}}, sq_y[31:4]} + {22'd0, center_y_reg};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_x_reg     <= div_reg[NS].fault ? 32'd0 : res_x;
            pix_y_reg     <= div_reg[NS].fault ? 32'd0 : res_y;
            pix_fault_reg <= div_reg[NS].fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            pix_valid_reg <= div_valid_reg[NS];
        end
    end

    assign pix.valid        = pix_valid_reg;
    assign pix.screen_x     = signed'(pix_x_reg);
    assign pix.screen_y     = signed'(pix_y_reg);
    assign pix.divide_fault = pix_fault_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // No request is taken while the matrix is being rebuilt.
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !vtx.ready)
        else $error("request accepted during matrix rebuild");

    // A frame request starts the sequencer from its first step.
    a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
        frame_accept |=> (busy_reg && (seq_step_reg == 4'd0)))
        else $error("frame request did not start rebuild");

    // The sequencer finishes after its last step.
    a_seq_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (seq_step_reg == vrp_pkg::SEQ_LAST)) |=> !busy_reg)
        else $error("rebuild sequencer overran");

    // A frame request never enters the result pipeline.
    a_frame_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        frame_accept |=> !s1_valid_reg)
        else $error("frame request produced a result slot");

    // A faulted result carries zero coordinates.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.divide_fault) |-> ((pix_x_reg == 32'd0) && (pix_y_reg == 32'd0)))
        else $error("fault result with nonzero coordinates");

endmodule

`default_nettype wire

[dv/vertex_rotate_perspective_project_core_tb.sv]
// ============================================================================
// vertex_rotate_perspective_project_core_tb: rotate and project regression
// Drives vertex and frame requests in random bursts, reprograms the registers
// between phases and checks every projected point against a cycle-free
// prediction of the rotation matrix, the shift-multiply and the shift-divide.
// ============================================================================
`default_nettype none

module vertex_rotate_perspective_project_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        command;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } vertex_req_t;

    typedef struct {
        logic [31:0] sx;
        logic [31:0] sy;
        logic        fault;
    } screen_pt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel, penable, pwrite;
    logic [vrp_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    vrp_vertex_if vtx ();
    vrp_screen_if pix ();

    vertex_rotate_perspective_project_core uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .vtx(vtx.sink), .pix(pix.source)
    );

    always #4 clk = ~clk;

    // Predicted block state.
    logic [31:0] depth_off, cen_x, cen_y;
    logic [7:0]  inc_x, inc_y, inc_z;
    logic [7:0]  ang_x, ang_y, ang_z;
    logic [31:0] rot [9];

    vertex_req_t pending_reqs [$];
    screen_pt_t  expected_pts [$];
    int errors = 0;
    logic req_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    logic long_hold_req = 1'b0;
    int idle_cycles = 0;

    function automatic logic [31:0] shift_mul(input logic [31:0] a, input logic [31:0] b);
        longint pa, pb, p;
        logic [31:0] w;
        pa = longint'($signed(a)) >>> 6;
        pb = longint'($signed(b)) >>> 6;
        p = pa * pb;
        w = p[31:0];
        return $signed(w) >>> 4;
    endfunction

    function automatic logic [31:0] shift_div(input logic [31:0] a, input longint d);
        logic [31:0] sh;
        longint n, q;
        logic [31:0] w;
        sh = a << 6;
        n = longint'($signed(sh));
        q = n / d;
        w = q[31:0];
        return $signed(w) >>> 4;
    endfunction

    // Sine in 16:16 from quarter-wave symmetry of the table.
    function automatic logic [31:0] sine_fix(input logic [7:0] a);
        int v;
        case (a[7:6])
            2'd0: v = vrp_pkg::QUARTER_SINE[a[5:0]];
            2'd1: v = vrp_pkg::QUARTER_SINE[64 - a[5:0]];
            2'd2: v = -int'(vrp_pkg::QUARTER_SINE[a[5:0]]);
            default: v = -int'(vrp_pkg::QUARTER_SINE[64 - a[5:0]]);
        endcase
        return 32'(v * 256);
    endfunction

    task automatic rebuild_rotation();
        logic [31:0] sx, sy, sz, cx, cy, cz;
        sx = sine_fix(ang_x);
        sy = sine_fix(ang_y);
        sz = sine_fix(ang_z);
        cx = sine_fix(ang_x + 8'd64);
        cy = sine_fix(ang_y + 8'd64);
        cz = sine_fix(ang_z + 8'd64);
        rot[0] = shift_mul(cx, cz) + shift_mul(shift_mul(sx, sy), sz);
        rot[3] = shift_mul(shift_mul(cx, sx), sy) - shift_mul(cx, sz);
        rot[6] = shift_mul(cy, sx);
        rot[1] = shift_mul(cy, sz);
        rot[4] = shift_mul(cy, cz);
        rot[7] = 32'd0 - sy;
        rot[2] = shift_mul(shift_mul(cx, sy), sz) - shift_mul(cz, sx);
        rot[5] = shift_mul(sx, sz) + shift_mul(shift_mul(cx, cz), sy);
        rot[8] = shift_mul(cx, cy);
    endtask

    // Apply one accepted request; vertices queue a projected point.
    task automatic project_request(input vertex_req_t r);
        logic [31:0] rx, ry, rz;
        longint d;
        screen_pt_t pt;
        if (r.command == vrp_pkg::CMD_FRAME)
        begin
            ang_x = ang_x + inc_x;
            ang_y = ang_y + inc_y;
            ang_z = ang_z + inc_z;
            rebuild_rotation();
            return;
        end
        rx = shift_mul(r.vx, rot[0]) + shift_mul(r.vy, rot[3]) + shift_mul(r.vz, rot[6]);
        ry = shift_mul(r.vx, rot[1]) + shift_mul(r.vy, rot[4]) + shift_mul(r.vz, rot[7]);
        rz = shift_mul(r.vx, rot[2]) + shift_mul(r.vy, rot[5]) + shift_mul(r.vz, rot[8])
             + (depth_off << 16);
        d = longint'($signed(rz) >>> 6);
        if (d == 0)
        begin
            pt.sx = '0;
            pt.sy = '0;
            pt.fault = 1'b1;
        end
        else
        begin
            pt.sx = cen_x + shift_div(rx, d);
            pt.sy = cen_y + shift_div(ry, d);
            pt.fault = 1'b0;
        end
        expected_pts.push_back(pt);
    endtask

    // Register write over APB; the predicted copy follows after the access edge.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= vrp_pkg::APB_ADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            vrp_pkg::REG_DEPTH_OFFSET: depth_off = {17'd0, data[14:0]};
            vrp_pkg::REG_CENTER_X: cen_x = {22'd0, data[9:0]};
            vrp_pkg::REG_CENTER_Y: cen_y = {22'd0, data[9:0]};
            vrp_pkg::REG_STEP_X: inc_x = data[7:0];
            vrp_pkg::REG_STEP_Y: inc_y = data[7:0];
            vrp_pkg::REG_STEP_Z: inc_z = data[7:0];
            default: ;
        endcase
    endtask

    task automatic push_req(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        vertex_req_t r;
        r.command = cmd;
        r.vx = x;
        r.vy = y;
        r.vz = z;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return 32'($urandom_range(0, 40 * 65536)) - 32'(20 * 65536);
        endcase
    endfunction

    task automatic wait_drained();
        wait (pending_reqs.size() == 0 && expected_pts.size() == 0 && !vtx.valid);
        repeat (50) @(posedge clk);
    endtask

    // Request driver: bursts with random gaps, held until accepted.
    always @(negedge clk)
    begin
        if (req_taken)
            void'(pending_reqs.pop_front());
        if (vtx.valid && !req_taken)
        begin
        end
        else if (gap_left > 0)
        begin
            vtx.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_reqs.size() > 0)
        begin
            vtx.valid <= 1'b1;
            vtx.command <= pending_reqs[0].command;
            vtx.vertex_x <= pending_reqs[0].vx;
            vtx.vertex_y <= pending_reqs[0].vy;
            vtx.vertex_z <= pending_reqs[0].vz;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
        else
        begin
            vtx.valid <= 1'b0;
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    always @(negedge clk)
    begin
        if (long_hold_req && hold_left == 0)
        begin
            long_hold_req <= 1'b0;
            hold_left <= 400;
            pix.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            pix.ready <= (hold_left == 1);
        end
        else
        begin
            pix.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    // Request capture and result checking at the rising edge.
    always @(posedge clk)
    begin
        vertex_req_t r;
        screen_pt_t pt;
        req_taken <= vtx.valid && vtx.ready;
        if (vtx.valid && vtx.ready)
        begin
            r.command = vtx.command;
            r.vx = vtx.vertex_x;
            r.vy = vtx.vertex_y;
            r.vz = vtx.vertex_z;
            project_request(r);
        end
        if (pix.valid && pix.ready)
        begin
            if (expected_pts.size() == 0)
            begin
                $display("%0t: unexpected point x=%h y=%h fault=%b", $realtime,
                         pix.screen_x, pix.screen_y, pix.divide_fault);
                errors++;
            end
            else
            begin
                pt = expected_pts.pop_front();
                if (pix.screen_x !== pt.sx)
                begin
                    $display("%0t: screen_x expected %h actual %h", $realtime, pt.sx,
                             pix.screen_x);
                    errors++;
                end
                if (pix.screen_y !== pt.sy)
                begin
                    $display("%0t: screen_y expected %h actual %h", $realtime, pt.sy,
                             pix.screen_y);
                    errors++;
                end
                if (pix.divide_fault !== pt.fault)
                begin
                    $display("%0t: divide_fault expected %b actual %b", $realtime, pt.fault,
                             pix.divide_fault);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no traffic at all.
    always @(posedge clk)
    begin
        if ((vtx.valid && vtx.ready) || (pix.valid && pix.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int n;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        vtx.valid = 1'b0;
        vtx.command = vrp_pkg::CMD_VERTEX;
        vtx.vertex_x = '0;
        vtx.vertex_y = '0;
        vtx.vertex_z = '0;
        pix.ready = 1'b1;
        depth_off = 32'(vrp_pkg::DEPTH_OFFSET_RST);
        cen_x = 32'(vrp_pkg::CENTER_X_RST);
        cen_y = 32'(vrp_pkg::CENTER_Y_RST);
        inc_x = vrp_pkg::STEP_X_RST;
        inc_y = vrp_pkg::STEP_Y_RST;
        inc_z = vrp_pkg::STEP_Z_RST;
        ang_x = '0;
        ang_y = '0;
        ang_z = '0;
        for (int i = 0; i < 9; i++)
            rot[i] = (i % 4 == 0) ? vrp_pkg::FIX_ONE : '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity matrix, default registers first.
        push_req(vrp_pkg::CMD_VERTEX, 32'd0, 32'd0, 32'd0);
        push_req(vrp_pkg::CMD_VERTEX, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        push_req(vrp_pkg::CMD_VERTEX, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        push_req(vrp_pkg::CMD_VERTEX, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        wait_drained();

        // Zero depth: zero divisor and the wrapping quotient.
        reg_write(vrp_pkg::REG_DEPTH_OFFSET, 32'd0);
        push_req(vrp_pkg::CMD_VERTEX, 32'd65536, 32'd65536, 32'd0);
        push_req(vrp_pkg::CMD_VERTEX, 32'd5, 32'd7, 32'd63);
        push_req(vrp_pkg::CMD_VERTEX, 32'h0200_0000, 32'h0200_0000, 32'hffff_ffc0);
        push_req(vrp_pkg::CMD_VERTEX, 32'h0200_0000, 32'h0100_0000, 32'hffff_ffc0);
        push_req(vrp_pkg::CMD_VERTEX, 32'd65536, 32'd65536, 32'd64);
        push_req(vrp_pkg::CMD_FRAME, 32'd0, 32'd0, 32'd0);
        push_req(vrp_pkg::CMD_VERTEX, 32'd65536, 32'hfffe_0000, 32'd655360);
        push_req(vrp_pkg::CMD_FRAME, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_req(vrp_pkg::CMD_VERTEX, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_req(vrp_pkg::CMD_VERTEX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        wait_drained();

        // Register settings, extremes first, then random phases.
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                begin
                    reg_write(vrp_pkg::REG_DEPTH_OFFSET, 32'd32767);
                    reg_write(vrp_pkg::REG_CENTER_X, 32'd1023);
                    reg_write(vrp_pkg::REG_CENTER_Y, 32'd1023);
                    reg_write(vrp_pkg::REG_STEP_X, 32'd255);
                    reg_write(vrp_pkg::REG_STEP_Y, 32'd255);
                    reg_write(vrp_pkg::REG_STEP_Z, 32'd255);
                end
                1:
                begin
                    reg_write(vrp_pkg::REG_DEPTH_OFFSET, 32'd1);
                    reg_write(vrp_pkg::REG_CENTER_X, 32'd0);
                    reg_write(vrp_pkg::REG_CENTER_Y, 32'd0);
                    reg_write(vrp_pkg::REG_STEP_X, 32'd0);
                    reg_write(vrp_pkg::REG_STEP_Y, 32'd0);
                    reg_write(vrp_pkg::REG_STEP_Z, 32'd0);
                end
                default:
                begin
                    reg_write(vrp_pkg::REG_DEPTH_OFFSET, $urandom);
                    reg_write(vrp_pkg::REG_CENTER_X, $urandom);
                    reg_write(vrp_pkg::REG_CENTER_Y, $urandom);
                    reg_write(vrp_pkg::REG_STEP_X, $urandom);
                    reg_write(vrp_pkg::REG_STEP_Y, $urandom);
                    reg_write(vrp_pkg::REG_STEP_Z, $urandom);
                    if (ph == 3)
                        reg_write(vrp_pkg::REG_DEPTH_OFFSET, $urandom_range(0, 40));
                end
            endcase
            if (ph == 2)
                long_hold_req = 1'b1;
            n = 215;
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 5) == 0)
                    push_req(vrp_pkg::CMD_FRAME, $urandom, $urandom, $urandom);
                else
                    push_req(vrp_pkg::CMD_VERTEX, rand_coord(), rand_coord(), rand_coord());
            end
            wait_drained();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
